// File: rtl/ltc_pkg.sv
// ltc_pkg: shared types, character constants and ASCII class helpers
// for the log token classifier. No dependencies.

package ltc_pkg;

  // default bound on counted characters per token
  localparam int unsigned MAX_TOKEN_LEN_DEF = 256;

  // fixed field widths of the beats
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned START_W = 8;
  localparam int unsigned LEN_W   = 9;

  typedef logic [CHAR_W-1:0] char_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_WORD   = 2'd0,
    CLASS_NUMBER = 2'd1,
    CLASS_HYBRID = 2'd2
  } class_t;

  // character codes
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;
  localparam char_t CH_X     = 8'h78;
  localparam char_t CH_NL    = 8'h0A;
  localparam char_t CH_DOT   = 8'h2E;
  localparam char_t CH_COMMA = 8'h2C;
  localparam char_t CH_UP_A  = 8'h41;
  localparam char_t CH_UP_F  = 8'h46;
  localparam char_t CH_UP_Z  = 8'h5A;
  localparam char_t CH_LO_A  = 8'h61;
  localparam char_t CH_LO_F  = 8'h66;
  localparam char_t CH_LO_Z  = 8'h7A;

  // one result beat
  typedef struct packed {
    class_t             token_class;
    logic [START_W-1:0] keep_start;
    logic [LEN_W-1:0]   keep_length;
    logic [LEN_W-1:0]   token_length;
    logic               too_long;
  } result_t;

  function automatic logic is_letter(char_t c);
    is_letter = ((c >= CH_UP_A) && (c <= CH_UP_Z)) || ((c >= CH_LO_A) && (c <= CH_LO_Z));
  endfunction

  function automatic logic is_digit(char_t c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_hex_digit(char_t c);
    is_hex_digit = is_digit(c) || ((c >= CH_UP_A) && (c <= CH_UP_F)) ||
                   ((c >= CH_LO_A) && (c <= CH_LO_F));
  endfunction

endpackage

// File: rtl/ltc_char_if.sv
// ltc_char_if: input channel carrying one token character per beat.
// Depends on ltc_pkg.

interface ltc_char_if;
  import ltc_pkg::*;

  logic  valid;
  logic  ready;
  char_t token_char;
  logic  last_char;

  modport source (output valid, output token_char, output last_char, input ready);
  modport sink   (input valid, input token_char, input last_char, output ready);
endinterface

// File: rtl/ltc_result_if.sv
// ltc_result_if: output channel carrying one token classification per beat.
// Depends on ltc_pkg.

interface ltc_result_if;
  import ltc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CLASS_W-1:0] token_class;
  logic [START_W-1:0] keep_start;
  logic [LEN_W-1:0]   keep_length;
  logic [LEN_W-1:0]   token_length;
  logic               too_long;

  modport source (output valid, output token_class, output keep_start, output keep_length,
                  output token_length, output too_long, input ready);
  modport sink   (input valid, input token_class, input keep_start, input keep_length,
                  input token_length, input too_long, output ready);
endinterface

// File: rtl/log_token_classifier.sv
// Log token classifier: takes one character per cycle and ends a token on the
// beat flagged last_char, then issues one result beat (class, kept substring,
// length, overflow). Throughput is one character per cycle with no gaps between
// tokens; the result is registered: the last character lands in the input register,
// and the result register loads from it once its slot is free. Input stalls only
// while a last character sits in the input register and the result register still
// holds an earlier result that is not being taken.

// log_token_classifier: top level, joins the scan stage and the result register.
// Depends on ltc_pkg, ltc_char_if, ltc_result_if, ltc_scan, ltc_result_reg.

module log_token_classifier #(
  parameter int unsigned MAX_TOKEN_LEN = ltc_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic         clk,
  input  logic         rst,
  ltc_char_if.sink     chars,
  ltc_result_if.source result
);
  import ltc_pkg::*;

  logic    res_valid;
  logic    res_ready;
  result_t res;

  // character scan and state update
  ltc_scan #(
    .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  // result output register
  ltc_result_reg u_result_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .result    (result)
  );
endmodule

// File: rtl/ltc_scan.sv
// ltc_scan: input register plus per-character token state and classification.
// Depends on ltc_pkg and ltc_char_if.

module ltc_scan #(
  parameter int unsigned MAX_TOKEN_LEN = ltc_pkg::MAX_TOKEN_LEN_DEF
) (
  input  logic             clk,
  input  logic             rst,
  ltc_char_if.sink         chars,
  input  logic             res_ready,
  output logic             res_valid,
  output ltc_pkg::result_t res
);
  import ltc_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_TOKEN_LEN + 1);
  localparam int unsigned EXT_W = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TOKEN_LEN);
  localparam logic [POS_W-1:0] POS_ONE = POS_W'(1);

  // input register
  logic  in_valid;
  char_t in_char;
  logic  in_last;
  logic  step;

  // token state
  logic [POS_W-1:0] position;
  class_t           cur_class;
  logic             decided;
  logic             hex_mode;
  logic             sep_used;
  logic             first_zero;
  logic             letter_found;
  logic [POS_W-1:0] letter_start;
  logic             run_end_found;
  logic [POS_W-1:0] run_end;
  logic             overflow;

  logic [POS_W-1:0] position_next;
  class_t           cur_class_next;
  logic             decided_next;
  logic             hex_mode_next;
  logic             sep_used_next;
  logic             first_zero_next;
  logic             letter_found_next;
  logic [POS_W-1:0] letter_start_next;
  logic             run_end_found_next;
  logic [POS_W-1:0] run_end_next;
  logic             overflow_next;

  logic             c_letter;
  logic             c_digit;
  logic [POS_W-1:0] stop;
  logic [EXT_W-1:0] keep;
  logic [EXT_W-1:0] start;

  // a character leaves the input register unless it ends a token and the result slot is full
  assign step        = in_valid && (!in_last || res_ready);
  assign chars.ready = !in_valid || step;
  assign res_valid   = in_valid && in_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (chars.ready) begin
      in_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      in_char <= chars.token_char;
      in_last <= chars.last_char;
    end
  end

  assign c_letter = is_letter(in_char);
  assign c_digit  = is_digit(in_char);

  // per-character state update
  always_comb begin
    position_next      = position;
    cur_class_next     = cur_class;
    decided_next       = decided;
    hex_mode_next      = hex_mode;
    sep_used_next      = sep_used;
    first_zero_next    = first_zero;
    letter_found_next  = letter_found;
    letter_start_next  = letter_start;
    run_end_found_next = run_end_found;
    run_end_next       = run_end;
    overflow_next      = overflow;

    if (position >= POS_MAX) begin
      overflow_next = 1'b1;
    end else begin
      // first letter run tracking
      if (!letter_found && c_letter) begin
        letter_found_next = 1'b1;
        letter_start_next = position;
      end else if (letter_found && !run_end_found && !c_letter) begin
        run_end_found_next = 1'b1;
        run_end_next       = position;
      end

      // class decision
      if (!decided) begin
        if (position == '0) begin
          first_zero_next = (in_char == CH_ZERO);
          if (c_digit || (in_char == CH_MINUS) || (in_char == CH_PLUS)) begin
            cur_class_next = CLASS_NUMBER;
          end else if (c_letter) begin
            cur_class_next = CLASS_WORD;
          end else begin
            cur_class_next = CLASS_HYBRID;
            decided_next   = 1'b1;
          end
        end else if ((position == POS_ONE) && first_zero && (in_char == CH_X)) begin
          hex_mode_next = 1'b1;
        end else if (in_last && (in_char == CH_NL)) begin
          // trailing newline leaves the class alone
          decided_next = decided;
        end else if (hex_mode) begin
          if (!is_hex_digit(in_char)) begin
            cur_class_next = CLASS_HYBRID;
            decided_next   = 1'b1;
          end
        end else if ((cur_class == CLASS_NUMBER) && c_letter) begin
          cur_class_next = CLASS_HYBRID;
          decided_next   = 1'b1;
        end else if ((cur_class == CLASS_WORD) && c_digit) begin
          cur_class_next = CLASS_HYBRID;
          decided_next   = 1'b1;
        end else if (!c_letter && !c_digit) begin
          if ((cur_class == CLASS_NUMBER) && !sep_used &&
              ((in_char == CH_DOT) || (in_char == CH_COMMA))) begin
            sep_used_next = 1'b1;
          end else begin
            cur_class_next = CLASS_HYBRID;
            decided_next   = 1'b1;
          end
        end
      end

      position_next = position + POS_ONE;
    end
  end

  // result from the updated state
  always_comb begin
    stop  = run_end_found_next ? run_end_next : position_next;
    start = '0;
    keep  = EXT_W'(position_next);
    if (cur_class_next == CLASS_HYBRID) begin
      if (letter_found_next) begin
        start = EXT_W'(letter_start_next);
        keep  = EXT_W'(stop - letter_start_next);
      end else begin
        keep = '0;
      end
    end
    res.token_class  = cur_class_next;
    res.keep_start   = start[START_W-1:0];
    res.keep_length  = keep[LEN_W-1:0];
    res.token_length = LEN_W'(position_next);
    res.too_long     = overflow_next;
  end

  // state registers: back to idle values after the last character
  always_ff @(posedge clk) begin
    if (rst || (step && in_last)) begin
      position      <= '0;
      cur_class     <= CLASS_WORD;
      decided       <= 1'b0;
      hex_mode      <= 1'b0;
      sep_used      <= 1'b0;
      first_zero    <= 1'b0;
      letter_found  <= 1'b0;
      letter_start  <= '0;
      run_end_found <= 1'b0;
      run_end       <= '0;
      overflow      <= 1'b0;
    end else if (step) begin
      position      <= position_next;
      cur_class     <= cur_class_next;
      decided       <= decided_next;
      hex_mode      <= hex_mode_next;
      sep_used      <= sep_used_next;
      first_zero    <= first_zero_next;
      letter_found  <= letter_found_next;
      letter_start  <= letter_start_next;
      run_end_found <= run_end_found_next;
      run_end       <= run_end_next;
      overflow      <= overflow_next;
    end
  end
endmodule

// File: rtl/ltc_result_reg.sv
// ltc_result_reg: output register holding one result beat until taken.
// Depends on ltc_pkg and ltc_result_if.

module ltc_result_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  ltc_pkg::result_t res,
  output logic             res_ready,
  ltc_result_if.source     result
);
  import ltc_pkg::*;

  logic    held_valid;
  result_t held;

  // slot is free when empty or being drained this cycle
  assign res_ready = !held_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (res_ready) begin
      held_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      held <= res;
    end
  end

  // drive the output beat
  assign result.valid        = held_valid;
  assign result.token_class  = held.token_class;
  assign result.keep_start   = held.keep_start;
  assign result.keep_length  = held.keep_length;
  assign result.token_length = held.token_length;
  assign result.too_long     = held.too_long;
endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for log_token_classifier; streams tokens one character
// per beat and checks every result beat against a built-in classifier model or a typed row.
// Depends on ltc_pkg, ltc_char_if, ltc_result_if and the classifier RTL.

module tb;
  import ltc_pkg::*;

  localparam int unsigned TOKEN_MAX = 256;

  // directed row: token text, and the result when it is obvious by inspection
  typedef struct {
    string   text;
    bit      typed;
    result_t want;
  } token_row_t;

  logic clk = 1'b0;
  logic rst;

  ltc_char_if   chars ();
  ltc_result_if result ();

  log_token_classifier #(
    .MAX_TOKEN_LEN(TOKEN_MAX)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .chars (chars),
    .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // classifier state mirrored by the bench
  logic [8:0] pos;
  class_t     tok_class;
  logic       decided;
  logic       hex_seen;
  logic       sep_seen;
  logic       lead_zero;
  logic       seen_letter;
  logic [7:0] letter_pos;
  logic       run_closed;
  logic [8:0] run_stop;
  logic       overflow;

  result_t    expected_results[$];
  char_t      spell[$];
  bit         use_typed;
  result_t    typed_want;
  int         gap_pct;
  int         stall_pct;
  int         fails;
  int         chars_sent;
  int         tokens_sent;
  int         tail_len;
  int         n_word, n_number, n_hybrid, n_long;

  token_row_t directed_rows[12] = '{
    '{"a",      1'b1, '{CLASS_WORD,   8'd0, 9'd1, 9'd1, 1'b0}},
    '{"9",      1'b1, '{CLASS_NUMBER, 8'd0, 9'd1, 9'd1, 1'b0}},
    '{"\n",     1'b1, '{CLASS_HYBRID, 8'd0, 9'd0, 9'd1, 1'b0}},
    '{"\377",   1'b1, '{CLASS_HYBRID, 8'd0, 9'd0, 9'd1, 1'b0}},
    '{"0x",     1'b1, '{CLASS_NUMBER, 8'd0, 9'd2, 9'd2, 1'b0}},
    '{"Zz\n",   1'b0, '0},
    '{"-4.2",   1'b0, '0},
    '{"0xaF",   1'b0, '0},
    '{"0xg",    1'b0, '0},
    '{"+,.",    1'b0, '0},
    '{"a\nb",   1'b0, '0},
    '{"7q",     1'b0, '0}
  };

  function bit alpha(input char_t c);
    alpha = (c >= CH_UP_A && c <= CH_UP_Z) || (c >= CH_LO_A && c <= CH_LO_Z);
  endfunction

  function bit numeral(input char_t c);
    numeral = (c >= CH_ZERO && c <= CH_NINE);
  endfunction

  function bit hex_numeral(input char_t c);
    hex_numeral = numeral(c) || (c >= CH_UP_A && c <= CH_UP_F) ||
                  (c >= CH_LO_A && c <= CH_LO_F);
  endfunction

  // append one character to the token being built
  function void add_char(input char_t c);
    spell = {spell, c};
  endfunction

  function void clear_token();
    pos         = '0;
    tok_class   = CLASS_WORD;
    decided     = 1'b0;
    hex_seen    = 1'b0;
    sep_seen    = 1'b0;
    lead_zero   = 1'b0;
    seen_letter = 1'b0;
    letter_pos  = '0;
    run_closed  = 1'b0;
    run_stop    = '0;
    overflow    = 1'b0;
  endfunction

  function void go_hybrid();
    tok_class = CLASS_HYBRID;
    decided   = 1'b1;
  endfunction

  // class update for one counted character
  function void sort_char(input char_t c, input bit last);
    if (decided) begin
    end else if (pos == 0) begin
      lead_zero = (c == CH_ZERO);
      if (numeral(c) || c == CH_MINUS || c == CH_PLUS) tok_class = CLASS_NUMBER;
      else if (alpha(c)) tok_class = CLASS_WORD;
      else go_hybrid();
    end else if (pos == 1 && lead_zero && c == CH_X) begin
      hex_seen = 1'b1;
    end else if (last && c == CH_NL) begin
      // trailing newline leaves the class alone
    end else if (hex_seen) begin
      if (!hex_numeral(c)) go_hybrid();
    end else if (tok_class == CLASS_NUMBER && alpha(c)) begin
      go_hybrid();
    end else if (tok_class == CLASS_WORD && numeral(c)) begin
      go_hybrid();
    end else if (!alpha(c) && !numeral(c)) begin
      if (tok_class == CLASS_NUMBER && !sep_seen && (c == CH_DOT || c == CH_COMMA))
        sep_seen = 1'b1;
      else
        go_hybrid();
    end
  endfunction

  // advance one character; returns 1 with the token summary on the last one
  function bit take_char(input char_t c, input bit last, output result_t r);
    logic [8:0] stop;
    r = '0;
    if (pos >= TOKEN_MAX) begin
      overflow = 1'b1;
    end else begin
      if (!seen_letter && alpha(c)) begin
        seen_letter = 1'b1;
        letter_pos  = pos[7:0];
      end else if (seen_letter && !run_closed && !alpha(c)) begin
        run_closed = 1'b1;
        run_stop   = pos;
      end
      sort_char(c, last);
      pos = pos + 9'd1;
    end
    take_char = last;
    if (last) begin
      r.token_class  = tok_class;
      r.keep_start   = '0;
      r.keep_length  = pos;
      r.token_length = pos;
      r.too_long     = overflow;
      if (tok_class == CLASS_HYBRID) begin
        if (seen_letter) begin
          stop          = run_closed ? run_stop : pos;
          r.keep_start  = letter_pos;
          r.keep_length = stop - {1'b0, letter_pos};
        end else begin
          r.keep_length = '0;
        end
      end
      clear_token();
    end
  endfunction

  function char_t any_letter();
    any_letter = $urandom_range(0, 1) ? char_t'(CH_UP_A + $urandom_range(0, 25))
                                      : char_t'(CH_LO_A + $urandom_range(0, 25));
  endfunction

  function char_t any_digit();
    any_digit = char_t'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function char_t any_hex();
    case ($urandom_range(0, 2))
      0:       any_hex = any_digit();
      1:       any_hex = char_t'(CH_UP_A + $urandom_range(0, 5));
      default: any_hex = char_t'(CH_LO_A + $urandom_range(0, 5));
    endcase
  endfunction

  // full byte range, with the two extreme codes drawn more often
  function char_t any_byte();
    if ($urandom_range(0, 7) == 0) any_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    else any_byte = char_t'($urandom_range(0, 255));
  endfunction

  task build_number();
    int n, sep_at;
    case ($urandom_range(0, 2))
      0: add_char(CH_MINUS);
      1: add_char(CH_PLUS);
      default: ;
    endcase
    n      = $urandom_range(1, 8);
    sep_at = $urandom_range(0, 1) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == sep_at) add_char($urandom_range(0, 1) ? CH_DOT : CH_COMMA);
      add_char(any_digit());
    end
  endtask

  task build_hex();
    add_char(CH_ZERO);
    add_char(CH_X);
    repeat ($urandom_range(0, 6)) add_char(any_hex());
  endtask

  task build_letters();
    repeat ($urandom_range(1, 10)) add_char(any_letter());
  endtask

  // one random token: half well formed, the rest junk around letters, corrupted or noise
  task build_token();
    int kind, spot;
    spell.delete();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      build_letters();
    end else if (kind < 35) begin
      build_number();
    end else if (kind < 50) begin
      build_hex();
    end else if (kind < 70) begin
      // leading junk, a letter run, trailing junk
      repeat ($urandom_range(0, 3))
        add_char($urandom_range(0, 2) == 0 ? CH_DOT : any_digit());
      repeat ($urandom_range(1, 6)) add_char(any_letter());
      repeat ($urandom_range(0, 3)) add_char(any_byte());
    end else if (kind < 85) begin
      case ($urandom_range(0, 2))
        0:       build_number();
        1:       build_hex();
        default: build_letters();
      endcase
      spot        = $urandom_range(0, spell.size() - 1);
      spell[spot] = any_byte();
    end else begin
      repeat ($urandom_range(1, 6)) add_char(any_byte());
    end
    if ($urandom_range(0, 3) == 0) add_char(CH_NL);
  endtask

  // drive one character beat and record its prediction once accepted
  task send_char(input char_t c, input bit last);
    result_t r;
    while ($urandom_range(0, 99) < gap_pct) begin
      chars.valid <= 1'b0;
      @(posedge clk);
    end
    chars.valid      <= 1'b1;
    chars.token_char <= c;
    chars.last_char  <= last;
    @(posedge clk);
    while (!chars.ready) @(posedge clk);
    chars_sent++;
    if (take_char(c, last, r)) begin
      expected_results = {expected_results, (use_typed ? typed_want : r)};
      tokens_sent++;
    end
  endtask

  task send_spell();
    for (int i = 0; i < spell.size(); i++)
      send_char(spell[i], i == spell.size() - 1);
  endtask

  // hold the sender until every pending result is out
  task drain();
    chars.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task check_field(input string name, input logic [8:0] want, input logic [8:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no token pending");
        fails++;
      end else begin
        want = expected_results.pop_front();
        check_field("token_class", want.token_class, result.token_class);
        check_field("keep_start", want.keep_start, result.keep_start);
        check_field("keep_length", want.keep_length, result.keep_length);
        check_field("token_length", want.token_length, result.token_length);
        check_field("too_long", want.too_long, result.too_long);
        case (want.token_class)
          CLASS_WORD:   n_word++;
          CLASS_NUMBER: n_number++;
          default:      n_hybrid++;
        endcase
        if (want.too_long) n_long++;
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb failed");
    $finish;
  end

  // main sequence
  initial begin
    fails       = 0;
    chars_sent  = 0;
    tokens_sent = 0;
    n_word      = 0;
    n_number    = 0;
    n_hybrid    = 0;
    n_long      = 0;
    use_typed   = 1'b0;
    gap_pct     = 19;
    stall_pct   = 19;
    clear_token();
    rst              <= 1'b1;
    chars.valid      <= 1'b0;
    chars.token_char <= '0;
    chars.last_char  <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed tokens
    foreach (directed_rows[k]) begin
      spell.delete();
      for (int i = 0; i < directed_rows[k].text.len(); i++)
        add_char(directed_rows[k].text[i]);
      use_typed  = directed_rows[k].typed;
      typed_want = directed_rows[k].want;
      send_spell();
      use_typed = 1'b0;
    end
    drain();

    // random tokens, with a stretch of full-rate traffic on both sides
    while (chars_sent < 170) begin
      if (chars_sent >= 60 && chars_sent < 130) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = 19;
        stall_pct = 19;
      end
      build_token();
      send_spell();
    end

    // one to eight past the bound, with the only counted letter on the last counted character
    spell.delete();
    tail_len = $urandom_range(1, 8);
    for (int i = 0; i < TOKEN_MAX + tail_len; i++)
      add_char(i < TOKEN_MAX - 1 ? any_digit() : (i == TOKEN_MAX - 1 ? any_letter()
                                                                     : any_byte()));
    send_spell();
    drain();
    repeat (10) @(posedge clk);

    $display("sent %0d characters in %0d tokens", chars_sent, tokens_sent);
    $display("checked %0d words, %0d numbers, %0d hybrids, %0d over length",
             n_word, n_number, n_hybrid, n_long);
    if (fails == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
